// File: sv/mrm_pkg.sv
// Shared widths, grow-mode codes and the offset helper for the motif record merge block.
package mrm_pkg;

    // Field widths fixed by the record format
    localparam int FREQ_W      = 16;
    localparam int SCORE_W     = 24;
    localparam int BASE_CNT_W  = 60;
    localparam int MATCH_CNT_W = 40;
    localparam int MODE_W      = 2;

    // Element counts of the packed count vectors
    localparam int BASE_ELEMS  = 6;
    localparam int MATCH_ELEMS = 4;
    localparam int MATCH_IDX_W = $clog2(MATCH_ELEMS);
    localparam int OFF_W       = 2;

    // Score arithmetic: products, numerator, total frequency
    localparam int PROD_W = FREQ_W + SCORE_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int TOT_W  = FREQ_W + 1;
    localparam int QUOT_W = SCORE_W;

    // Parameter defaults
    localparam int MOTIF_LEN_DEF  = 4;
    localparam int COUNT_BITS_DEF = 10;

    // Grow mode codes
    localparam logic [MODE_W-1:0] GROW_CENTRE = 2'd0;
    localparam logic [MODE_W-1:0] GROW_LEFT   = 2'd1;
    localparam logic [MODE_W-1:0] GROW_RIGHT  = 2'd2;

    // Placement offsets of the match counts
    localparam logic [OFF_W-1:0] OFF_LEFT   = 2'd0;
    localparam logic [OFF_W-1:0] OFF_CENTRE = 2'd1;
    localparam logic [OFF_W-1:0] OFF_RIGHT  = 2'd2;

    // Map a grow mode to its placement offset; the unused code acts as centre
    function automatic logic [OFF_W-1:0] offset_of(input logic [MODE_W-1:0] mode);
        logic [OFF_W-1:0] off;
        case (mode)
            GROW_LEFT:  off = OFF_LEFT;
            GROW_RIGHT: off = OFF_RIGHT;
            default:    off = OFF_CENTRE;
        endcase
        return off;
    endfunction

endpackage

// File: sv/mrm_count_lane.sv
// One count lane: holds one running position count and folds in its match element.
module mrm_count_lane #(
    parameter int LANE       = 0,
    parameter int MOTIF_LEN  = 4,
    parameter int COUNT_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_first,
    input  logic [COUNT_BITS-1:0]               i_base_cnt,
    input  logic [mrm_pkg::MATCH_CNT_W-1:0]     i_match_counts,
    input  logic [mrm_pkg::OFF_W-1:0]           i_offset,
    output logic [COUNT_BITS-1:0]               o_cnt,
    output logic                                o_clip
);
    import mrm_pkg::*;

    localparam logic [3:0] LANE_POS = 4'(LANE);
    localparam logic [3:0] LEN_LIM  = 4'(MOTIF_LEN);

    logic [COUNT_BITS-1:0]  r_cnt;
    logic [COUNT_BITS-1:0]  n_cnt;
    logic [COUNT_BITS-1:0]  w_eff;
    logic [COUNT_BITS-1:0]  w_elem;
    logic [COUNT_BITS:0]    w_sum;
    logic [3:0]             w_diff;
    logic [MATCH_IDX_W-1:0] w_idx;
    logic                   w_hit;

    // Pick the match element that lands on this lane, if any
    always_comb begin
        w_diff = LANE_POS - {2'b00, i_offset};
        w_hit  = (LANE_POS >= {2'b00, i_offset}) && (w_diff < LEN_LIM);
        w_idx  = w_diff[MATCH_IDX_W-1:0];
        w_elem = i_match_counts[w_idx*COUNT_BITS +: COUNT_BITS];
    end

    // Add with saturation on the base or the running count
    always_comb begin
        w_eff  = i_first ? i_base_cnt : r_cnt;
        w_sum  = {1'b0, w_eff} + {1'b0, w_elem};
        o_clip = w_hit && w_sum[COUNT_BITS];
        if (!w_hit) begin
            n_cnt = w_eff;
        end else if (w_sum[COUNT_BITS]) begin
            n_cnt = '1;
        end else begin
            n_cnt = w_sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

// File: sv/mrm_divider.sv
// Radix-2 restoring divider for the weighted mean score, one quotient bit per cycle.
module mrm_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mrm_pkg::NUM_W-1:0]    i_num,
    input  logic [mrm_pkg::TOT_W-1:0]    i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [mrm_pkg::QUOT_W-1:0]   o_quot
);
    import mrm_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [TOT_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_lo;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TOT_W:0]    w_trial;
    logic [TOT_W:0]    w_diff;
    logic              w_qbit;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_lo[QUOT_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_qbit  = (w_trial >= {1'b0, r_den});
    end

    // Control: count quotient bits, flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
            r_busy <= (r_cnt != CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the upper dividend bits start below the divisor, so the quotient fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[NUM_W-1:QUOT_W];
            r_lo   <= i_num[QUOT_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_qbit ? w_diff[TOT_W-1:0] : w_trial[TOT_W-1:0];
            r_lo   <= {r_lo[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sv/motif_record_merge_top.sv
// Top level of the motif record merge block: count lanes, score divider, merge and output.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------------------
//  input    | in        | i_valid / o_stall          | i_first, i_last, i_base_*, i_match_*
//  result   | out       | o_valid / i_stall          | o_merged_*, o_saturated
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_grow_mode
//
// Each item passes in order through the accept, the multiply, the divider load, the quotient
// bits, the divider done and the merge; o_stall holds off the next item until the block is idle.
// A zero total skips the divider; lanes finish on accept.
// Reset is synchronous and active low and clears the running record and the mode.
// A result waiting on i_stall holds in the output register while the next item is
// accepted and worked on; it only blocks when a second result is ready to load.
module motif_record_merge_top #(
    parameter int MOTIF_LEN  = mrm_pkg::MOTIF_LEN_DEF,
    parameter int COUNT_BITS = mrm_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_first,
    input  logic                             i_last,
    input  logic [mrm_pkg::FREQ_W-1:0]       i_base_freq,
    input  logic [mrm_pkg::SCORE_W-1:0]      i_base_score,
    input  logic [mrm_pkg::BASE_CNT_W-1:0]   i_base_counts,
    input  logic [mrm_pkg::FREQ_W-1:0]       i_match_freq,
    input  logic [mrm_pkg::SCORE_W-1:0]      i_match_score,
    input  logic [mrm_pkg::MATCH_CNT_W-1:0]  i_match_counts,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mrm_pkg::FREQ_W-1:0]       o_merged_freq,
    output logic [mrm_pkg::SCORE_W-1:0]      o_merged_score,
    output logic [mrm_pkg::BASE_CNT_W-1:0]   o_merged_counts,
    output logic                             o_saturated,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrm_pkg::MODE_W-1:0]       i_cfg_grow_mode
);
    import mrm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    logic [MODE_W-1:0]   r_grow_mode;
    logic [FREQ_W-1:0]   r_run_freq;
    logic [SCORE_W-1:0]  r_run_score;
    logic                r_clip;

    logic [FREQ_W-1:0]   r_op_rf;
    logic [SCORE_W-1:0]  r_op_rs;
    logic [FREQ_W-1:0]   r_op_mf;
    logic [SCORE_W-1:0]  r_op_ms;
    logic [TOT_W-1:0]    r_tot;
    logic                r_last;
    logic [PROD_W-1:0]   r_prod0;
    logic [PROD_W-1:0]   r_prod1;

    logic                r_out_valid;
    logic [FREQ_W-1:0]   r_out_freq;
    logic [SCORE_W-1:0]  r_out_score;
    logic [BASE_CNT_W-1:0] r_out_counts;
    logic                r_out_sat;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_out_free;
    logic                w_emit;
    logic [OFF_W-1:0]    w_offset;
    logic [FREQ_W-1:0]   w_eff_rf;
    logic [SCORE_W-1:0]  w_eff_rs;
    logic [TOT_W-1:0]    w_tot;
    logic [FREQ_W-1:0]   w_new_freq;
    logic                w_freq_clip;
    logic                w_lane_clip_any;
    logic [NUM_W-1:0]    w_num;
    logic [SCORE_W-1:0]  w_new_score;
    logic [BASE_CNT_W-1:0] w_counts;
    logic                w_div_start;
    logic                w_div_busy;
    logic                w_div_done;
    logic [QUOT_W-1:0]   w_quot;

    logic [COUNT_BITS-1:0] w_lane_cnt  [BASE_ELEMS];
    logic [BASE_ELEMS-1:0] w_lane_clip;

    // Handshakes
    assign o_stall     = (r_state != S_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = r_out_valid && !i_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;
    assign w_offset    = offset_of(r_grow_mode);

    // Grow mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow_mode <= GROW_CENTRE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grow_mode <= i_cfg_grow_mode;
        end
    end

    // Count lanes: one per position of the longer record
    for (genvar l = 0; l < BASE_ELEMS; l++) begin : g_lane
        mrm_count_lane #(
            .LANE       (l),
            .MOTIF_LEN  (MOTIF_LEN),
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_load         (w_in_acc),
            .i_first        (i_first),
            .i_base_cnt     (i_base_counts[l*COUNT_BITS +: COUNT_BITS]),
            .i_match_counts (i_match_counts),
            .i_offset       (w_offset),
            .o_cnt          (w_lane_cnt[l]),
            .o_clip         (w_lane_clip[l])
        );
    end

    // Merge lane counts into the packed vector, unused bits zero
    always_comb begin
        w_counts = '0;
        for (int l = 0; l < BASE_ELEMS; l++) begin
            w_counts[l*COUNT_BITS +: COUNT_BITS] = w_lane_cnt[l];
        end
    end

    assign w_lane_clip_any = |w_lane_clip;

    // Frequency fold with saturation
    always_comb begin
        w_eff_rf    = i_first ? i_base_freq  : r_run_freq;
        w_eff_rs    = i_first ? i_base_score : r_run_score;
        w_tot       = {1'b0, w_eff_rf} + {1'b0, i_match_freq};
        w_freq_clip = w_tot[FREQ_W];
        w_new_freq  = w_freq_clip ? '1 : w_tot[FREQ_W-1:0];
    end

    // Running frequency and clip flag update on accept; latch score operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_freq <= '0;
            r_clip     <= 1'b0;
        end else if (w_in_acc) begin
            r_run_freq <= w_new_freq;
            r_clip     <= (r_clip && !i_first) || w_lane_clip_any || w_freq_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op_rf <= w_eff_rf;
            r_op_rs <= w_eff_rs;
            r_op_mf <= i_match_freq;
            r_op_ms <= i_match_score;
            r_tot   <= w_tot;
            r_last  <= i_last;
        end
    end

    // Weighted products, registered before the sum
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod0 <= r_op_rf * r_op_rs;
            r_prod1 <= r_op_mf * r_op_ms;
        end
    end

    assign w_num       = {1'b0, r_prod0} + {1'b0, r_prod1};
    assign w_div_start = (r_state == S_LOAD) && (r_tot != '0);

    mrm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_tot),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // A zero total keeps the score
    assign w_new_score = (r_tot == '0) ? r_op_rs : w_quot;
    assign w_emit      = (r_state == S_DONE) && r_last && w_out_free;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = (r_tot == '0) ? S_DONE : S_DIV;
            S_DIV:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (!r_last || w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_score <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && (n_state == S_IDLE)) begin
                r_run_score <= w_new_score;
            end
        end
    end

    // Output register: hold until taken, load on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_freq   <= r_run_freq;
            r_out_score  <= w_new_score;
            r_out_counts <= w_counts;
            r_out_sat    <= r_clip;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_merged_freq   = r_out_freq;
    assign o_merged_score  = r_out_score;
    assign o_merged_counts = r_out_counts;
    assign o_saturated     = r_out_sat;

    // Checks
    a_state_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_idle_div_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_busy)
        else $error("divider busy while idle");

    a_accept_to_mul : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MUL))
        else $error("accepted item did not start the multiply");

    a_score_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_tot != '0))
            |-> ((w_quot <= r_op_rs) || (w_quot <= r_op_ms)))
        else $error("mean score exceeds both operands");

endmodule
